FILE: design/hsbl_pkg.sv
package hsbl_pkg;

   // Word length of one transfer on the serial link.
   localparam int DATA_BITS = 8;
   localparam int CNT_W     = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_SEND = 2'd1;
   localparam logic [1:0] REQ_RECV = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_SEND = 2'd1,
      MODE_RECV = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] tx_byte;
      logic       clock_in;
      logic       partner_in;
   } req_type;

   typedef struct packed {
      logic       clock_out;
      logic       clock_drive;
      logic       own_line_out;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       tx_done;
      logic       busy_res;
      logic       clock_seen;
   } rsp_type;

   typedef struct packed {
      mode_type               mode;
      logic [CNT_W-1:0]       bits_done;
      logic [DATA_BITS-1:0]   shift_reg;
      logic                   clock_level;
      logic                   own_level;
   } state_type;

endpackage

FILE: design/hsbl_step.sv
module hsbl_step (
   input  hsbl_pkg::state_type cur_state,
   input  hsbl_pkg::req_type   req,
   output hsbl_pkg::state_type next_state,
   output hsbl_pkg::rsp_type   rsp
);

   logic [hsbl_pkg::DATA_BITS+7:0] tx_ext;
   logic [hsbl_pkg::DATA_BITS-1:0] tx_word;
   logic [hsbl_pkg::DATA_BITS-1:0] shift_up;
   logic [hsbl_pkg::DATA_BITS-1:0] shift_rx;
   logic [hsbl_pkg::DATA_BITS+7:0] rx_ext;
   logic                           last_bit;
   logic                           rx_valid;
   logic                           tx_done;

   assign tx_ext   = {{hsbl_pkg::DATA_BITS{1'b0}}, req.tx_byte};
   assign tx_word  = tx_ext[hsbl_pkg::DATA_BITS-1:0];
   assign shift_up = cur_state.shift_reg << 1;
   assign shift_rx = shift_up | hsbl_pkg::DATA_BITS'(req.partner_in);
   assign rx_ext   = {8'b0, shift_rx};
   assign last_bit = (cur_state.bits_done == hsbl_pkg::CNT_W'(hsbl_pkg::DATA_BITS - 1));

   always_comb begin
      next_state = cur_state;
      rx_valid   = 1'b0;
      tx_done    = 1'b0;
      unique case (req.req_type)
         hsbl_pkg::REQ_SEND: begin
            // The first data bit is set together with the first clock rise.
            next_state.mode        = hsbl_pkg::MODE_SEND;
            next_state.bits_done   = '0;
            next_state.shift_reg   = tx_word;
            next_state.own_level   = tx_word[hsbl_pkg::DATA_BITS-1];
            next_state.clock_level = 1'b1;
         end
         hsbl_pkg::REQ_RECV: begin
            next_state.mode      = hsbl_pkg::MODE_RECV;
            next_state.bits_done = '0;
            next_state.shift_reg = '0;
            next_state.own_level = 1'b0;
         end
         default: begin
            unique case (cur_state.mode)
               hsbl_pkg::MODE_SEND: begin
                  if (req.partner_in == cur_state.clock_level) begin
                     if (last_bit) begin
                        tx_done              = 1'b1;
                        next_state.mode      = hsbl_pkg::MODE_IDLE;
                        next_state.bits_done = '0;
                     end else begin
                        next_state.bits_done   = cur_state.bits_done + hsbl_pkg::CNT_W'(1);
                        next_state.shift_reg   = shift_up;
                        next_state.own_level   = shift_up[hsbl_pkg::DATA_BITS-1];
                        next_state.clock_level = ~cur_state.clock_level;
                     end
                  end
               end
               hsbl_pkg::MODE_RECV: begin
                  // Each change of the clock level carries one data bit.
                  if (req.clock_in != cur_state.own_level) begin
                     next_state.shift_reg = shift_rx;
                     next_state.own_level = ~cur_state.own_level;
                     if (last_bit) begin
                        rx_valid             = 1'b1;
                        next_state.mode      = hsbl_pkg::MODE_IDLE;
                        next_state.bits_done = '0;
                     end else begin
                        next_state.bits_done = cur_state.bits_done + hsbl_pkg::CNT_W'(1);
                     end
                  end
               end
               default: begin
                  next_state.mode = hsbl_pkg::MODE_IDLE;
               end
            endcase
         end
      endcase
   end

   always_comb begin
      rsp.clock_out    = next_state.clock_level;
      rsp.clock_drive  = (next_state.mode == hsbl_pkg::MODE_SEND);
      rsp.own_line_out = next_state.own_level;
      rsp.rx_byte      = rx_valid ? rx_ext[7:0] : 8'd0;
      rsp.rx_valid     = rx_valid;
      rsp.tx_done      = tx_done;
      rsp.busy_res     = (next_state.mode != hsbl_pkg::MODE_IDLE);
      rsp.clock_seen   = (next_state.mode == hsbl_pkg::MODE_IDLE) ? req.clock_in : 1'b0;
   end

endmodule

FILE: design/handshake_serial_byte_link.sv
// Handshaked three-wire serial link, one byte at a time, most significant bit first.
// The request channel carries one item per sampled pin tick, or a command to start
// sending a byte or to start receiving one. Each request yields exactly one response
// on the rsp_ channel, showing the link state after that request: the clock level and
// whether it is driven, the own line (data when sending, acknowledge when receiving),
// a received byte with rx_valid, tx_done, busy and the idle clock indication.
// The response is registered: a request accepted at one edge has its response valid
// after that edge. Throughput is one request per cycle while the receiver does not
// stall, set by the single state update and response register; a new request is
// taken in the same cycle that the previous response is taken.
// When the receiver stalls, the response register holds its item and req_ready drops
// until it is taken; no request is lost and the link state does not advance.
// Reset puts the link idle with clock and own lines low, the bit counter and shift
// register cleared and no response pending.
module handshake_serial_byte_link (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hsbl_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hsbl_pkg::rsp_type rsp_payload
);

   hsbl_pkg::state_type state_ff;
   hsbl_pkg::state_type state_in;
   hsbl_pkg::rsp_type   rsp_payload_ff;
   hsbl_pkg::rsp_type   rsp_payload_in;
   logic                rsp_valid_ff;
   logic                req_accept;

   hsbl_step u_step (
      .cur_state  (state_ff),
      .req        (req_payload),
      .next_state (state_in),
      .rsp        (rsp_payload_in)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{mode: hsbl_pkg::MODE_IDLE, default: '0};
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   a_done_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.rx_valid && rsp_payload.tx_done))
      else $error("rx_valid and tx_done in the same response");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.clock_drive |-> rsp_payload.busy_res && !rsp_payload.clock_seen)
      else $error("clock driven while idle or clock indication while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.rx_valid || rsp_payload.tx_done) |-> !rsp_payload.busy_res)
      else $error("transfer finished but link still busy");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request refused with empty response register");
`endif

endmodule

FILE: bench/hsbl_link_checker.sv
`timescale 1ns / 1ps

module hsbl_link_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  hsbl_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  hsbl_pkg::rsp_type rsp_payload,
   output int                mismatches,
   output int                pending,
   output int                rx_count,
   output int                tx_count
);

   hsbl_pkg::mode_type             link_mode;
   int                             bit_count;
   logic [hsbl_pkg::DATA_BITS-1:0] shifter;
   logic                           clk_lvl;
   logic                           own_lvl;
   hsbl_pkg::rsp_type              link_status_q[$];

   // Applies one request to the shadow copy of the link and returns the status it must report.
   function automatic hsbl_pkg::rsp_type advance_link(input hsbl_pkg::req_type r);
      hsbl_pkg::rsp_type o;
      o = '0;
      if (r.req_type == hsbl_pkg::REQ_SEND) begin
         link_mode = hsbl_pkg::MODE_SEND;
         bit_count = 0;
         shifter   = hsbl_pkg::DATA_BITS'(r.tx_byte);
         own_lvl   = shifter[hsbl_pkg::DATA_BITS-1];
         clk_lvl   = 1'b1;
      end else if (r.req_type == hsbl_pkg::REQ_RECV) begin
         link_mode = hsbl_pkg::MODE_RECV;
         bit_count = 0;
         shifter   = '0;
         own_lvl   = 1'b0;
      end else if (link_mode == hsbl_pkg::MODE_SEND) begin
         if (r.partner_in == clk_lvl) begin
            bit_count++;
            if (bit_count >= hsbl_pkg::DATA_BITS) begin
               o.tx_done = 1'b1;
               link_mode = hsbl_pkg::MODE_IDLE;
               bit_count = 0;
            end else begin
               shifter = shifter << 1;
               own_lvl = shifter[hsbl_pkg::DATA_BITS-1];
               clk_lvl = ~clk_lvl;
            end
         end
      end else if (link_mode == hsbl_pkg::MODE_RECV) begin
         // A new bit arrives whenever the clock line differs from our acknowledge level.
         if (r.clock_in != own_lvl) begin
            shifter = (shifter << 1) | hsbl_pkg::DATA_BITS'(r.partner_in);
            own_lvl = ~own_lvl;
            bit_count++;
            if (bit_count >= hsbl_pkg::DATA_BITS) begin
               o.rx_valid = 1'b1;
               o.rx_byte  = 8'(shifter);
               link_mode  = hsbl_pkg::MODE_IDLE;
               bit_count  = 0;
            end
         end
      end
      o.clock_out    = clk_lvl;
      o.clock_drive  = (link_mode == hsbl_pkg::MODE_SEND);
      o.own_line_out = own_lvl;
      o.busy_res     = (link_mode != hsbl_pkg::MODE_IDLE);
      o.clock_seen   = (link_mode == hsbl_pkg::MODE_IDLE) ? r.clock_in : 1'b0;
      return o;
   endfunction

   task automatic compare_field(input string fname, input logic [7:0] want,
                                input logic [7:0] seen);
      if (seen !== want) begin
         if (mismatches < 10) begin
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, seen);
         end
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      hsbl_pkg::rsp_type want;
      if (reset) begin
         link_mode = hsbl_pkg::MODE_IDLE;
         bit_count = 0;
         shifter   = '0;
         clk_lvl   = 1'b0;
         own_lvl   = 1'b0;
         link_status_q.delete();
         mismatches = 0;
         rx_count   = 0;
         tx_count   = 0;
         pending   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            link_status_q.push_back(advance_link(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            if (link_status_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: response %0h arrived with no request waiting", $time,
                           rsp_payload);
               end
               mismatches++;
            end else begin
               want = link_status_q.pop_front();
               compare_field("clock_out", 8'(want.clock_out), 8'(rsp_payload.clock_out));
               compare_field("clock_drive", 8'(want.clock_drive), 8'(rsp_payload.clock_drive));
               compare_field("own_line_out", 8'(want.own_line_out),
                             8'(rsp_payload.own_line_out));
               compare_field("rx_byte", want.rx_byte, rsp_payload.rx_byte);
               compare_field("rx_valid", 8'(want.rx_valid), 8'(rsp_payload.rx_valid));
               compare_field("tx_done", 8'(want.tx_done), 8'(rsp_payload.tx_done));
               compare_field("busy_res", 8'(want.busy_res), 8'(rsp_payload.busy_res));
               compare_field("clock_seen", 8'(want.clock_seen), 8'(rsp_payload.clock_seen));
               if (want.rx_valid) begin
                  rx_count++;
               end
               if (want.tx_done) begin
                  tx_count++;
               end
            end
         end
         pending <= link_status_q.size();
      end
   end

endmodule

FILE: bench/tb_handshake_serial_byte_link.sv
`timescale 1ns / 1ps

module tb_handshake_serial_byte_link;

   // Request code outside the defined set; the link must treat it as a pin tick.
   localparam logic [1:0] REQ_SPARE   = 2'd3;
   localparam int         ITEM_TARGET = 1400;
   localparam int         QUIET_ITEMS = 150;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   hsbl_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   hsbl_pkg::rsp_type rsp_payload;

   int mismatches;
   int pending;
   int rx_count;
   int tx_count;
   int items_sent  = 0;
   int send_starts = 0;
   int recv_starts = 0;
   int tick_items  = 0;
   bit gap_on      = 1'b0;
   bit stall_on    = 1'b0;

   handshake_serial_byte_link dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   hsbl_link_checker link_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .pending     (pending),
      .rx_count    (rx_count),
      .tx_count    (tx_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Response side: ready drops in random bursts while stalling is enabled.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic issue(input logic [1:0] code, input logic [7:0] data, input logic clk_lvl,
                        input logic partner);
      hsbl_pkg::req_type r;
      r.req_type   = code;
      r.tx_byte    = data;
      r.clock_in   = clk_lvl;
      r.partner_in = partner;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (code == hsbl_pkg::REQ_SEND) begin
         send_starts++;
      end else if (code == hsbl_pkg::REQ_RECV) begin
         recv_starts++;
      end else begin
         tick_items++;
      end
      if (gap_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Plays the receiving partner of a send: it acknowledges each clock level, sometimes late.
   task automatic run_send(input logic [7:0] data, input int acks, input int max_wait);
      logic level;
      issue(hsbl_pkg::REQ_SEND, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      level = 1'b1;
      for (int i = 0; i < acks; i++) begin
         repeat ($urandom_range(0, max_wait)) begin
            issue(hsbl_pkg::REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  ~level);
         end
         issue(hsbl_pkg::REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               level);
         level = ~level;
      end
   endtask

   // Plays the sending partner of a receive: it flips the clock once per bit, MSB first.
   task automatic run_recv(input logic [7:0] data, input int bits, input int max_wait);
      logic ack_level;
      issue(hsbl_pkg::REQ_RECV, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
      ack_level = 1'b0;
      for (int i = 0; i < bits; i++) begin
         repeat ($urandom_range(0, max_wait)) begin
            issue(hsbl_pkg::REQ_TICK, 8'($urandom_range(0, 255)), ack_level,
                  1'($urandom_range(0, 1)));
         end
         issue(hsbl_pkg::REQ_TICK, 8'($urandom_range(0, 255)), ~ack_level, data[7-i]);
         ack_level = ~ack_level;
      end
   endtask

   initial begin
      int  pick;
      int  guard;
      bit  drained;
      drained      = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Idle clock indication, the unused code, full transfers, and restarts while busy.
      issue(hsbl_pkg::REQ_TICK, 8'h00, 1'b1, 1'b1);
      issue(hsbl_pkg::REQ_TICK, 8'hFF, 1'b0, 1'b0);
      issue(REQ_SPARE, 8'h5A, 1'b1, 1'b0);
      run_send(8'hFF, hsbl_pkg::DATA_BITS, 0);
      run_recv(8'h00, hsbl_pkg::DATA_BITS, 0);
      issue(hsbl_pkg::REQ_RECV, 8'h3C, 1'b0, 1'b1);
      issue(hsbl_pkg::REQ_SEND, 8'h00, 1'b1, 1'b0);
      issue(hsbl_pkg::REQ_RECV, 8'h80, 1'b1, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
            gap_on   = 1'b0;
            stall_on = 1'b0;
         end else if ($urandom_range(0, 15) == 0) begin
            gap_on   = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
         end
         if (!drained && items_sent >= ITEM_TARGET / 2) begin
            // Hold back requests until every response in flight has come out.
            req_valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
            drained = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            run_send(8'($urandom_range(0, 255)), hsbl_pkg::DATA_BITS, $urandom_range(0, 3));
         end else if (pick < 16) begin
            run_recv(8'($urandom_range(0, 255)), hsbl_pkg::DATA_BITS, $urandom_range(0, 3));
         end else if (pick < 18) begin
            // Transfer cut short by the next start request.
            if ($urandom_range(0, 1) == 1) begin
               run_send(8'($urandom_range(0, 255)),
                        $urandom_range(0, hsbl_pkg::DATA_BITS - 1), 2);
            end else begin
               run_recv(8'($urandom_range(0, 255)),
                        $urandom_range(0, hsbl_pkg::DATA_BITS - 1), 2);
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
      end

      req_valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending != 0 && guard < 1000);
      repeat (10) @(posedge clock);

      $display("Sent %0d requests: %0d send starts, %0d receive starts, %0d pin ticks.",
               items_sent, send_starts, recv_starts, tick_items);
      $display("Responses included %0d completed sends and %0d received bytes.",
               tx_count, rx_count);
      if (mismatches == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: handshake_serial_byte_link.f
design/hsbl_pkg.sv
design/hsbl_step.sv
design/handshake_serial_byte_link.sv
bench/hsbl_link_checker.sv
bench/tb_handshake_serial_byte_link.sv
